// ----- rtl/b2da_pkg.sv -----
// shared types and constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package b2da_pkg;

	// width of the binary word taken per conversion
	localparam int VALUE_W     = 32;
	// decimal digits held by the cell row, enough for any 32-bit word
	localparam int WORD_DIGITS = 10;
	// most digits one conversion may emit (1 to 20)
	localparam int MAX_DIGITS  = 10;
	// digits actually emitted at most, never more than the row holds
	localparam int EMIT_LIMIT  = (MAX_DIGITS < WORD_DIGITS) ? MAX_DIGITS : WORD_DIGITS;

	localparam int BCD_W       = 4;
	localparam int CHAR_W      = 6;
	localparam int BIT_CNT_W   = $clog2(VALUE_W);
	localparam int DIG_CNT_W   = $clog2(WORD_DIGITS + 1);

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
	localparam logic [BCD_W-1:0]   DABBLE_MIN = BCD_W'(5);
	localparam logic [BCD_W-1:0]   DABBLE_ADD = BCD_W'(3);

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// per-cycle command to every cell of the row
	typedef struct packed {
		logic clear;   // zero the digit
		logic dabble;  // add-3 adjust then shift one bit in
		logic dshift;  // take the lower neighbour's whole digit
	} cell_ctrl_t;

endpackage

// ----- rtl/b2da_cell.sv -----
// one bcd digit cell of the double dabble row
`timescale 1ns / 1ps

module b2da_cell
	import b2da_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              bit_in,
	input  logic [BCD_W-1:0]  digit_in,
	output logic              bit_out,
	output logic [BCD_W-1:0]  digit
);

	logic [BCD_W-1:0] digit_q;
	logic [BCD_W-1:0] adj;

	// add 3 when the digit would overflow after doubling
	always_comb begin
		if (digit_q >= DABBLE_MIN) begin
			adj = digit_q + DABBLE_ADD;
		end else begin
			adj = digit_q;
		end
	end

	assign bit_out = adj[BCD_W-1];
	assign digit   = digit_q;

	// digit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[BCD_W-2:0], bit_in};
		end else if (ctrl.dshift) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ----- rtl/binary_to_decimal_ascii_core.sv -----
// top level: binary to decimal ascii converter built on a row of bcd cells
`timescale 1ns / 1ps

// Converts one unsigned 32-bit value per command into its decimal ASCII
// digits, most significant first, no leading zeros; a zero value gives a
// single '0'. Pulse start while busy is low to hand in a word. Digits come
// out one per cycle on digit_char, each marked by digit_valid for exactly one
// cycle, with last_digit set on the final one; the receiver cannot stall and
// must take every digit as it appears. A conversion runs double dabble through
// the row of ten digit cells (one bit per cycle), sizes the number, then
// shifts digits through the same row (leading zeros are shifted out, then the
// digits are emitted); after the last digit busy falls and the next word can
// be taken.

module binary_to_decimal_ascii_core
	import b2da_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [VALUE_W-1:0]  value,
	output logic                digit_valid,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last_digit
);

	state_t                 state_q, state_d;
	logic [VALUE_W-1:0]     value_q;
	logic [BIT_CNT_W-1:0]   bit_cnt_q;
	logic [DIG_CNT_W-1:0]   skip_q, skip_d;
	logic [DIG_CNT_W-1:0]   left_q, left_d;
	cell_ctrl_t             ctrl;
	logic                   load;

	logic [WORD_DIGITS-1:0] carry;
	logic [BCD_W-1:0]       digits [WORD_DIGITS];
	logic [DIG_CNT_W-1:0]   n_sig;
	logic [DIG_CNT_W-1:0]   n_emit;

	// row of digit cells, cell 0 is the least significant
	for (genvar i = 0; i < WORD_DIGITS; i++) begin : g_cell
		logic             bin;
		logic [BCD_W-1:0] din;
		if (i == 0) begin : g_first
			assign bin = value_q[VALUE_W-1];
			assign din = '0;
		end else begin : g_rest
			assign bin = carry[i-1];
			assign din = digits[i-1];
		end
		b2da_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.bit_in   (bin),
			.digit_in (din),
			.bit_out  (carry[i]),
			.digit    (digits[i])
		);
	end

	// count of significant digits, at least one, and that count capped at EMIT_LIMIT
	always_comb begin
		n_sig = DIG_CNT_W'(1);
		for (int i = 0; i < WORD_DIGITS; i++) begin
			if (digits[i] != '0) begin
				n_sig = DIG_CNT_W'(i + 1);
			end
		end
		if (n_sig > DIG_CNT_W'(EMIT_LIMIT)) begin
			n_emit = DIG_CNT_W'(EMIT_LIMIT);
		end else begin
			n_emit = n_sig;
		end
	end

	// state register and skip and digit-left counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			skip_q  <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			skip_q  <= skip_d;
			left_q  <= left_d;
		end
	end

	// binary word shifter and bit counter
	always_ff @(posedge clk) begin
		if (load) begin
			value_q   <= value;
			bit_cnt_q <= '0;
		end else if (ctrl.dabble) begin
			value_q   <= {value_q[VALUE_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
		end
	end

	// next state and cell commands
	always_comb begin
		state_d     = state_q;
		skip_d      = skip_q;
		left_d      = left_q;
		ctrl        = '0;
		load        = 1'b0;
		digit_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					load       = 1'b1;
					ctrl.clear = 1'b1;
					state_d    = ST_CONV;
				end
			end
			ST_CONV: begin
				ctrl.dabble = 1'b1;
				if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
					state_d = ST_SIZE;
				end
			end
			ST_SIZE: begin
				skip_d = DIG_CNT_W'(WORD_DIGITS) - n_emit;
				left_d = n_emit;
				if (n_emit == DIG_CNT_W'(WORD_DIGITS)) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				ctrl.dshift = 1'b1;
				skip_d      = skip_q - DIG_CNT_W'(1);
				if (skip_q == DIG_CNT_W'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				ctrl.dshift = 1'b1;
				digit_valid = 1'b1;
				left_d      = left_q - DIG_CNT_W'(1);
				if (left_q == DIG_CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// busy flag, result digit from the top cell and last-digit flag
	assign busy       = (state_q != ST_IDLE);
	assign digit_char = ASCII_ZERO + CHAR_W'(digits[WORD_DIGITS-1]);
	assign last_digit = (left_q == DIG_CNT_W'(1));

endmodule

// ----- tb/sv/binary_to_decimal_ascii_core_tb.sv -----
// testbench for the binary to decimal ascii converter: directed table, then random words
`timescale 1ns / 1ps

module binary_to_decimal_ascii_core_tb
	import b2da_pkg::*;
();

	localparam int unsigned DEC_BASE   = 10;
	localparam int          N_RANDOM   = 500;
	localparam int          MAX_GAP    = 16;
	localparam int          DRAIN_CYC  = 60;
	localparam int          N_DIRECTED = 22;

	// one expected digit on the output side
	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              is_last;
	} digit_t;

	// one row of the directed table; empty text means the predictor supplies the digits
	typedef struct {
		logic [VALUE_W-1:0] word;
		string              text;
	} vector_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               start       = 1'b0;
	logic [VALUE_W-1:0] value       = '0;
	logic               busy;
	logic               digit_valid;
	logic [CHAR_W-1:0]  digit_char;
	logic               last_digit;

	digit_t pending_digits[$];
	int     error_count = 0;
	bit     burst_mode  = 1'b0;

	int unsigned dec_pow [0:9] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
		10000000, 100000000, 1000000000};

	vector_t directed_vectors [0:N_DIRECTED-1] = '{
		'{32'd0,          "0"},
		'{32'd1,          "1"},
		'{32'd9,          "9"},
		'{32'd10,         "10"},
		'{32'd99,         "99"},
		'{32'd100,        "100"},
		'{32'd65535,      "65535"},
		'{32'd999999999,  "999999999"},
		'{32'd1000000000, "1000000000"},
		'{32'd2147483647, "2147483647"},
		'{32'd2147483648, "2147483648"},
		'{32'd4000000000, "4000000000"},
		'{32'd4294967295, "4294967295"},
		'{32'h5555_5555,  ""},
		'{32'hAAAA_AAAA,  ""},
		'{32'h0000_FFFF,  ""},
		'{32'hFFFF_0000,  ""},
		'{32'd12345,      ""},
		'{32'd1000,       ""},
		'{32'd1000000001, ""},
		'{32'd7,          ""},
		'{32'd4294967294, ""}
	};

	binary_to_decimal_ascii_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.digit_valid (digit_valid),
		.digit_char  (digit_char),
		.last_digit  (last_digit)
	);

	// clock
	always #1 clk = ~clk;

	// decimal digits of a word, most significant first, capped at MAX_DIGITS low digits
	function automatic void queue_decimal_digits(input logic [VALUE_W-1:0] word);
		logic [BCD_W-1:0]   dig [0:WORD_DIGITS-1];
		logic [VALUE_W-1:0] rest;
		int                 n;
		int                 emit;
		digit_t             d;
		rest = word;
		n    = 0;
		do begin
			dig[n] = BCD_W'(rest % DEC_BASE);
			rest   = rest / DEC_BASE;
			n++;
		end while (rest != 0 && n < WORD_DIGITS);
		emit = (n < MAX_DIGITS) ? n : MAX_DIGITS;
		if (emit < 1) begin
			emit = 1;
		end
		for (int k = 0; k < emit; k++) begin
			d.ch      = ASCII_ZERO + CHAR_W'(dig[emit - 1 - k]);
			d.is_last = (k == emit - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// expected digits typed in as text
	function automatic void queue_text_digits(input string text);
		logic [7:0] c;
		digit_t     d;
		for (int i = 0; i < text.len(); i++) begin
			c         = text[i];
			d.ch      = c[CHAR_W-1:0];
			d.is_last = (i == text.len() - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// hand one word to the block and record what it should produce
	task automatic send_word(input logic [VALUE_W-1:0] word, input string text);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			// sometimes let the gap start only once the block is free
			if ($urandom_range(0, 1) == 1) begin
				while (busy !== 1'b0) @(posedge clk);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= word;
		do @(posedge clk); while (busy !== 1'b0);
		if (text.len() > 0) begin
			queue_text_digits(text);
		end else begin
			queue_decimal_digits(word);
		end
	endtask

	// random word: full range, short numbers, or around powers of ten
	function automatic logic [VALUE_W-1:0] random_word();
		int unsigned k;
		case ($urandom_range(0, 4))
			0, 1: begin
				return $urandom;
			end
			2, 3: begin
				return $urandom >> $urandom_range(0, VALUE_W - 1);
			end
			default: begin
				k = $urandom_range(0, 9);
				return dec_pow[k] + $urandom_range(0, 2) - 1;
			end
		endcase
	endfunction

	// stimulus
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_word(directed_vectors[i].word, directed_vectors[i].text);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			// switch between back-to-back stretches and random gaps
			if (i % 40 == 0) begin
				burst_mode = ($urandom_range(0, 2) == 0);
			end
			send_word(random_word(), "");
		end
		start <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (error_count == 0) begin
			$display("binary_to_decimal_ascii_core_tb: done, clean");
		end else begin
			$display("binary_to_decimal_ascii_core_tb: done, errors");
		end
		$finish;
	end

	// compare each digit word with the oldest expectation
	always @(posedge clk) begin : check_digits
		digit_t want;
		if (arst_n && digit_valid === 1'b1) begin
			if (pending_digits.size() == 0) begin
				$error("digit_char: none expected, actual %0d", digit_char);
				error_count++;
			end else begin
				want = pending_digits.pop_front();
				if (digit_char !== want.ch) begin
					$error("digit_char: expected %0d, actual %0d", want.ch, digit_char);
					error_count++;
				end
				if (last_digit !== want.is_last) begin
					$error("last_digit: expected %0b, actual %0b", want.is_last, last_digit);
					error_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#500000;
		$display("binary_to_decimal_ascii_core_tb: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/b2da_pkg.sv
rtl/b2da_cell.sv
rtl/binary_to_decimal_ascii_core.sv
tb/sv/binary_to_decimal_ascii_core_tb.sv
